// ----- rtl/core/vps_pkg.sv -----
// Shared types and constants for the vector pair similarity block.
package vps_pkg;

    localparam int ACC_W   = 48;
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int NL_W    = 13;
    localparam logic [NL_W-1:0] NL_RESET = 13'd300;

    // accumulator totals of one finished vector pair
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        norm_a;
        logic [ACC_W-1:0]        norm_b;
        logic [ACC_W-1:0]        diff_sq;
    } t_snap;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_MUL,
        ST_DIVC,
        ST_DIVE,
        ST_SQE,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/core/vps_front.sv -----
// Front end: element products and saturating accumulation, one pair per cycle while not full.
module vps_front import vps_pkg::*; #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [ELEM_WIDTH-1:0] i_x_elem,
    input  logic signed [ELEM_WIDTH-1:0] i_y_elem,
    input  logic                         i_last_elem,
    input  logic [Q_CNT_W-1:0]           i_q_count,
    output logic                         o_q_push,
    output t_snap                        o_q_data
);

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int SW = (PW + 2 > ACC_W + 1) ? PW + 2 : ACC_W + 1;

    logic                 r_s1_valid, r_s1_last;
    logic signed [PW-1:0] r_pxy;
    logic [PW-1:0]        r_pxx, r_pyy;
    logic [PW:0]          r_pdd;

    logic signed [ACC_W-1:0] r_dot;
    logic [ACC_W-1:0]        r_na, r_nb, r_dist;

    logic signed [PW-1:0]       m_xy, m_xx, m_yy;
    logic signed [ELEM_WIDTH:0] m_d;
    logic signed [PW+1:0]       m_dd;
    logic                       accept;

    // room is kept for the item in stage one and the one taken now
    always_comb begin
        full   = (Q_CNT_W'(32'(i_q_count) + 32'(r_s1_valid)) >= Q_CNT_W'(Q_DEPTH - 1));
        accept = push && !full;
        m_xy   = i_x_elem * i_y_elem;
        m_xx   = i_x_elem * i_x_elem;
        m_yy   = i_y_elem * i_y_elem;
        m_d    = {i_x_elem[ELEM_WIDTH-1], i_x_elem} - {i_y_elem[ELEM_WIDTH-1], i_y_elem};
        m_dd   = m_d * m_d;
    end

    // stage one: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_last <= i_last_elem;
            r_pxy     <= m_xy;
            r_pxx     <= m_xx;
            r_pyy     <= m_yy;
            r_pdd     <= m_dd[PW:0];
        end
    end

    // stage two: saturating sums
    logic signed [SW-1:0] s_dot, smax, smin;
    logic [SW-1:0]        s_na, s_nb, s_dist, umax;
    logic signed [ACC_W-1:0] n_dot;
    logic [ACC_W-1:0]        n_na, n_nb, n_dist;

    always_comb begin
        smax   = {{(SW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
        smin   = {{(SW-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
        umax   = {{(SW-ACC_W){1'b0}}, {ACC_W{1'b1}}};
        s_dot  = SW'(r_dot) + SW'(r_pxy);
        s_na   = SW'(r_na) + SW'(r_pxx);
        s_nb   = SW'(r_nb) + SW'(r_pyy);
        s_dist = SW'(r_dist) + SW'(r_pdd);
        n_dot  = (s_dot > smax) ? smax[ACC_W-1:0] :
                 (s_dot < smin) ? smin[ACC_W-1:0] : s_dot[ACC_W-1:0];
        n_na   = (s_na > umax) ? umax[ACC_W-1:0] : s_na[ACC_W-1:0];
        n_nb   = (s_nb > umax) ? umax[ACC_W-1:0] : s_nb[ACC_W-1:0];
        n_dist = (s_dist > umax) ? umax[ACC_W-1:0] : s_dist[ACC_W-1:0];
        o_q_push         = r_s1_valid && r_s1_last;
        o_q_data.dot     = n_dot;
        o_q_data.norm_a  = n_na;
        o_q_data.norm_b  = n_nb;
        o_q_data.diff_sq = n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= '0;
            r_na   <= '0;
            r_nb   <= '0;
            r_dist <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_dot  <= '0;
                r_na   <= '0;
                r_nb   <= '0;
                r_dist <= '0;
            end else begin
                r_dot  <= n_dot;
                r_na   <= n_na;
                r_nb   <= n_nb;
                r_dist <= n_dist;
            end
        end
    end

endmodule

// ----- rtl/core/vps_queue.sv -----
// Short queue of accumulator totals between front and back.
module vps_queue import vps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_snap              i_data,
    input  logic               i_pop,
    output logic               o_empty,
    output t_snap              o_data,
    output logic [Q_CNT_W-1:0] o_count
);

    t_snap              r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers wrap over the power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/vps_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
module vps_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [34:0] rem2, trial;

    assign rem2   = {r_rem[32:0], r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) r_busy <= 1'b0;
            end
        end
    end

    // restoring digit step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

endmodule

// ----- rtl/core/vps_div.sv -----
// Restoring divider, one quotient bit per cycle.
module vps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [76:0] i_num,
    input  logic [61:0] i_den,
    output logic        o_done,
    output logic [76:0] o_quo
);

    logic [76:0] r_num, r_quo;
    logic [61:0] r_den;
    logic [62:0] r_rem, rem2;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;

    assign rem2   = {r_rem[61:0], r_num[76]};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 7'd76);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 7'd76) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[75:0], 1'b0};
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= rem2 - {1'b0, r_den};
                r_quo <= {r_quo[75:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_quo <= {r_quo[75:0], 1'b0};
            end
        end
    end

endmodule

// ----- rtl/core/vps_back.sv -----
// Back end: roots, divisions and the result register, one vector pair at a time.
module vps_back import vps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  t_snap                   i_q_data,
    output logic                    o_q_pop,
    input  logic [NL_W-1:0]         i_norm_length,
    output logic                    empty,
    input  logic                    pop,
    output logic [16:0]             o_cos_sim,
    output logic signed [18:0]      o_euclid_sim,
    output logic                    o_zero_norm
);

    t_state r_state, n_state;
    t_snap  r_snap;
    logic   r_zero, r_issued;
    logic [30:0] r_sa, r_sb;
    logic [61:0] r_p;
    logic [55:0] r_t;
    logic [16:0] r_cos;
    logic signed [18:0] r_eu;
    logic        r_out_valid;
    logic [16:0] r_out_cos;
    logic signed [18:0] r_out_eu;
    logic        r_out_zero;

    logic        sq_start, sq_done, dv_start, dv_done;
    logic [63:0] sq_rad;
    logic [31:0] sq_root;
    logic [76:0] dv_num, dv_quo;
    logic [61:0] dv_den;
    logic        head_zero, out_free;
    logic [47:0] mag;
    logic [NL_W-1:0] n_len;

    vps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    vps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    assign head_zero = (i_q_data.norm_a == '0) || (i_q_data.norm_b == '0);
    assign out_free  = !r_out_valid || pop;
    assign mag       = r_snap.dot[47] ? 48'(-r_snap.dot) : 48'(r_snap.dot);
    assign n_len     = (i_norm_length == '0) ? NL_W'(1) : i_norm_length;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = head_zero ? ST_DIVE : ST_SQA;
            ST_SQA:  if (sq_done) n_state = ST_SQB;
            ST_SQB:  if (sq_done) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIVC;
            ST_DIVC: if (dv_done) n_state = ST_DIVE;
            ST_DIVE: if (dv_done) n_state = ST_SQE;
            ST_SQE:  if (sq_done) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // unit starts and operand selection
    always_comb begin
        o_q_pop  = 1'b0;
        sq_start = 1'b0;
        dv_start = 1'b0;
        sq_rad   = '0;
        dv_num   = '0;
        dv_den   = '0;
        unique case (r_state)
            ST_IDLE: o_q_pop = !i_q_empty;
            ST_SQA: begin
                sq_start = !r_issued;
                sq_rad   = {2'b00, r_snap.norm_a, 14'd0};
            end
            ST_SQB: begin
                sq_start = !r_issued;
                sq_rad   = {2'b00, r_snap.norm_b, 14'd0};
            end
            ST_DIVC: begin
                dv_start = !r_issued;
                dv_num   = {mag, 29'd0};
                dv_den   = r_p;
            end
            ST_DIVE: begin
                dv_start = !r_issued;
                dv_num   = {21'd0, r_snap.diff_sq, 8'd0};
                dv_den   = {{(62-NL_W){1'b0}}, n_len};
            end
            ST_SQE: begin
                sq_start = !r_issued;
                sq_rad   = {8'd0, r_t};
            end
            default: ;
        endcase
    end

    // result arithmetic
    logic [20:0]        q_cap;
    logic signed [22:0] cos_w;
    logic [16:0]        cos_c;
    logic signed [29:0] eu_w;
    logic signed [18:0] eu_c;

    always_comb begin
        if ((|dv_quo[76:21]) || (dv_quo[20:0] > 21'h100000)) q_cap = 21'h100000;
        else q_cap = dv_quo[20:0];
        cos_w = r_snap.dot[47] ? (23'sd32768 - $signed({2'b00, q_cap}))
                               : (23'sd32768 + $signed({2'b00, q_cap}));
        if (cos_w < 0) cos_c = '0;
        else if (cos_w > 23'sd65536) cos_c = 17'd65536;
        else cos_c = cos_w[16:0];
        eu_w = 30'sd65536 - $signed({2'b00, sq_root[27:0]});
        // floor at -4.0
        eu_c = (eu_w < -30'sd262144) ? 19'h40000 : eu_w[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= (n_state == r_state) && (r_issued || sq_start || dv_start);
            if (r_state == ST_OUT && out_free) r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
        end
    end

    // datapath registers; the output beat is only reloaded once it is free
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && !i_q_empty) begin
            r_snap <= i_q_data;
            r_zero <= head_zero;
            r_cos  <= 17'd32768;
        end
        if (r_state == ST_SQA && sq_done) r_sa <= sq_root[30:0];
        if (r_state == ST_SQB && sq_done) r_sb <= sq_root[30:0];
        if (r_state == ST_MUL) r_p <= r_sa * r_sb;
        if (r_state == ST_DIVC && dv_done) r_cos <= cos_c;
        if (r_state == ST_DIVE && dv_done) r_t <= dv_quo[55:0];
        if (r_state == ST_SQE && sq_done) r_eu <= eu_c;
        if (r_state == ST_OUT && out_free) begin
            r_out_cos  <= r_cos;
            r_out_eu   <= r_eu;
            r_out_zero <= r_zero;
        end
    end

    assign empty        = !r_out_valid;
    assign o_cos_sim    = r_out_cos;
    assign o_euclid_sim = r_out_eu;
    assign o_zero_norm  = r_out_zero;

endmodule

// ----- rtl/core/vector_pair_similarity.sv -----
// Top level: cosine and euclidean similarity of two streamed vectors.
// Element pairs are taken one per cycle while full is low; a pair's products enter the sums in the following cycle.
// Results come from the bit-serial root and divider units; a zero norm skips the norm roots
// and the cosine division. The back end finishes one vector pair before it takes the next,
// while the front keeps accepting until the totals queue fills.
// Reset (synchronous, active low) clears sums, queue and result; norm_length becomes 300.
module vector_pair_similarity import vps_pkg::*; #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [ELEM_WIDTH-1:0] i_x_elem,
    input  logic signed [ELEM_WIDTH-1:0] i_y_elem,
    input  logic                         i_last_elem,
    output logic                         empty,
    input  logic                         pop,
    output logic [16:0]                  o_cos_sim,
    output logic signed [18:0]           o_euclid_sim,
    output logic                         o_zero_norm,
    input  logic                         i_cfg_we,
    input  logic [NL_W-1:0]              i_cfg_data
);

    logic [NL_W-1:0]    r_norm_length;
    logic               q_push, q_pop, q_empty;
    t_snap              q_wdata, q_rdata;
    logic [Q_CNT_W-1:0] q_count;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_length <= NL_RESET;
        end else if (i_cfg_we) begin
            r_norm_length <= i_cfg_data;
        end
    end

    vps_front #(.ELEM_WIDTH(ELEM_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_x_elem    (i_x_elem),
        .i_y_elem    (i_y_elem),
        .i_last_elem (i_last_elem),
        .i_q_count   (q_count),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    vps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata),
        .o_count (q_count)
    );

    vps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_norm_length (r_norm_length),
        .empty         (empty),
        .pop           (pop),
        .o_cos_sim     (o_cos_sim),
        .o_euclid_sim  (o_euclid_sim),
        .o_zero_norm   (o_zero_norm)
    );

endmodule

// ----- verif/vector_pair_similarity_checker.sv -----
// Checker for vector_pair_similarity: watches both queues, predicts results, compares them.
module vector_pair_similarity_checker import vps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [15:0] i_x_elem,
    input  logic signed [15:0] i_y_elem,
    input  logic               i_last_elem,
    input  logic               empty,
    input  logic               pop,
    input  logic [16:0]        o_cos_sim,
    input  logic signed [18:0] o_euclid_sim,
    input  logic               o_zero_norm,
    input  logic               i_cfg_we,
    input  logic [NL_W-1:0]    i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DOT_MAX = (64'sd1 <<< 47) - 1;
    localparam longint DOT_MIN = -(64'sd1 <<< 47);
    localparam longint unsigned SUM_MAX = (64'd1 << 48) - 1;

    typedef struct {
        logic [16:0]        cos_sim;
        logic signed [18:0] euclid_sim;
        logic               zero_norm;
    } t_sim_result;

    t_sim_result     sim_results[$];
    logic [NL_W-1:0] dim_count;
    longint          dot_sum;
    longint unsigned norm_x_sum, norm_y_sum, diff_sum;

    assign o_pending = sim_results.size();

    // floor square root, digit by digit
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits = bits >> 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    // add one element pair; on the last pair, queue the expected result
    task automatic take_pair(logic signed [15:0] xe, logic signed [15:0] ye, logic last);
        longint          x, y, d, s, cos_v, eu;
        longint unsigned sa, sb, mag, t, n;
        logic [127:0]    quo;
        t_sim_result     r;
        x = xe;
        y = ye;
        d = x - y;
        s = dot_sum + x * y;
        if (s > DOT_MAX) s = DOT_MAX;
        if (s < DOT_MIN) s = DOT_MIN;
        dot_sum = s;
        norm_x_sum = sat_add(norm_x_sum, x * x);
        norm_y_sum = sat_add(norm_y_sum, y * y);
        diff_sum = sat_add(diff_sum, d * d);
        if (!last) return;
        r.zero_norm = (norm_x_sum == 0) || (norm_y_sum == 0);
        if (r.zero_norm) begin
            cos_v = 32768;
        end else begin
            sa = int_sqrt(norm_x_sum << 14);
            sb = int_sqrt(norm_y_sum << 14);
            mag = (dot_sum < 0) ? longint'(-dot_sum) : longint'(dot_sum);
            quo = ({64'd0, mag} << 29) / {64'd0, sa * sb};
            if (quo > (128'd1 << 20)) quo = 128'd1 << 20;
            cos_v = (dot_sum < 0) ? 32768 - longint'(quo) : 32768 + longint'(quo);
            if (cos_v < 0) cos_v = 0;
            if (cos_v > 65536) cos_v = 65536;
        end
        n = (dim_count == 0) ? 1 : dim_count;
        t = (diff_sum << 8) / n;
        eu = 65536 - longint'(int_sqrt(t));
        if (eu < -262144) eu = -262144;
        r.cos_sim = cos_v[16:0];
        r.euclid_sim = eu[18:0];
        sim_results.insert(sim_results.size(), r);
        dot_sum = 0;
        norm_x_sum = 0;
        norm_y_sum = 0;
        diff_sum = 0;
    endtask

    always @(posedge i_clk) begin
        t_sim_result exp_r;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            dim_count <= NL_RESET;
            dot_sum = 0;
            norm_x_sum = 0;
            norm_y_sum = 0;
            diff_sum = 0;
            sim_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) dim_count <= i_cfg_data;
            if (push && !full) take_pair(i_x_elem, i_y_elem, i_last_elem);
            // result beat
            if (pop && !empty) begin
                if (sim_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    exp_r = sim_results.pop_front();
                    if (o_cos_sim !== exp_r.cos_sim) begin
                        $error("cos_sim expected %0d actual %0d", exp_r.cos_sim, o_cos_sim);
                        errs++;
                    end
                    if (o_euclid_sim !== exp_r.euclid_sim) begin
                        $error("euclid_sim expected %0d actual %0d",
                               exp_r.euclid_sim, o_euclid_sim);
                        errs++;
                    end
                    if (o_zero_norm !== exp_r.zero_norm) begin
                        $error("zero_norm expected %0d actual %0d",
                               exp_r.zero_norm, o_zero_norm);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

// ----- verif/vector_pair_similarity_test.sv -----
// Testbench top for vector_pair_similarity: stimulus, receiver stalls and verdict.
module vector_pair_similarity_test import vps_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk, i_rst_n;
    logic               push, full, empty, pop;
    logic signed [15:0] i_x_elem, i_y_elem;
    logic               i_last_elem;
    logic [16:0]        o_cos_sim;
    logic signed [18:0] o_euclid_sim;
    logic               o_zero_norm;
    logic               i_cfg_we;
    logic [NL_W-1:0]    i_cfg_data;
    int                 fail_count, pending;
    logic               hold_req;
    int                 items_sent;

    vector_pair_similarity i_dut (.*);

    vector_pair_similarity_checker i_chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("vector_pair_similarity_test NOT OK");
        $finish;
    end

    // receiver: changing stall pattern, plus one long hold-off on request
    initial begin
        int mode, left, hold;
        pop = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                for (hold = 0; hold < 3000; hold++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 400);
            end
            left--;
            case (mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'(int'($urandom_range(0, 15)) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    // one element pair beat, with a random gap before it now and then when gaps is set
    task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last,
                             bit gaps);
        if (gaps && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_x_elem <= x;
        i_y_elem <= y;
        i_last_elem <= last;
        // the beat is taken at the first rising edge that sees full low
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_vec(int len, int kind);
        logic signed [15:0] x, y;
        for (int k = 0; k < len; k++) begin
            x = rand_elem();
            y = rand_elem();
            case (kind)
                1: x = '0;
                2: y = x;
                3: y = -x;
                default: ;
            endcase
            send_pair(x, y, k == len - 1, 1'b1);
        end
        push <= 1'b0;
    endtask

    // wait for all results, then let the back end drain before a register write
    task automatic drain_and_write(logic [NL_W-1:0] v);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_vectors(int n_items);
        int start, len;
        start = items_sent;
        while (items_sent - start < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_vec(len, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
        end
    endtask

    initial begin
        logic [NL_W-1:0] dims[6];
        dims = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd300, 13'd37};
        items_sent = 0;
        hold_req = 1'b0;
        push = 1'b0;
        i_x_elem = '0;
        i_y_elem = '0;
        i_last_elem = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, zero norms, parallel and opposite vectors
        send_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
        send_pair(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b1, 1'b0);
        send_pair(16'sd0, 16'sd5, 1'b1, 1'b0);
        send_pair(-16'sd3, 16'sd0, 1'b1, 1'b0);
        send_pair(16'sd1, 16'sd1, 1'b1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1, 1'b0);
        send_pair(16'sd4096, 16'sd0, 1'b0, 1'b0);
        send_pair(16'sd0, 16'sd4096, 1'b1, 1'b0);
        send_pair(16'sh5555, 16'shaaaa, 1'b0, 1'b0);
        send_pair(16'shaaaa, 16'sh5555, 1'b1, 1'b0);
        send_vec(4, 2);
        send_vec(4, 3);
        send_vec(3, 1);

        // random phases across register settings
        foreach (dims[p]) begin
            drain_and_write((p == 5) ? NL_W'($urandom_range(1, 8191)) : dims[p]);
            if (p == 2) begin
                hold_req = 1'b1;
                random_vectors(60);
            end
            random_vectors(180);
        end
        push <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("vector_pair_similarity_test OK");
        end else begin
            $display("vector_pair_similarity_test NOT OK");
        end
        $finish;
    end
endmodule

// ----- vector_pair_similarity.f -----
rtl/core/vps_pkg.sv
rtl/core/vps_front.sv
rtl/core/vps_queue.sv
rtl/core/vps_sqrt.sv
rtl/core/vps_div.sv
rtl/core/vps_back.sv
rtl/core/vector_pair_similarity.sv
verif/vector_pair_similarity_checker.sv
verif/vector_pair_similarity_test.sv
